@@ src/bsmm_pkg.sv @@
// Package for the motion mask block: widths, register indexes, reset values.
`default_nettype none
package bsmm_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned AlphaW    = 17;
  localparam int unsigned ThrW      = 8;
  localparam int unsigned FracW     = 16;
  localparam int unsigned AccW      = PixW + FracW;    // Q16 background, always >= 0
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = AlphaW;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 16;

  localparam logic [AlphaW-1:0] AlphaOne   = 17'h10000;
  localparam logic [AlphaW-1:0] AlphaReset = 17'd3277;
  localparam logic [ThrW-1:0]   ThrReset   = 8'd20;
  localparam logic [FracW-1:0]  FracHalf   = 16'h8000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ALPHA     = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    CMD_PROCESS = 1'b0,
    CMD_LOAD    = 1'b1
  } cmd_e;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [AccW-1:0] acc_t;

endpackage
`default_nettype wire

@@ src/background_subtraction_motion_mask.sv @@
// Running-average background subtraction with a one-sided motion mask.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: gray; tuser: cmd, frame_start
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: motion, background
//  cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// One pixel per cycle unless the output stalls; each stage below ends in a register.
// Stages: frame store read, Q16 blend (one 18x9 multiply), compare/round/write-back.
// A same-address read behind a pending write is forwarded from the later stages.
// The whole pipeline advances together; it stalls only when the output word waits.
// Reset clears the address counter, the pipeline valids and the registers; the
// frame store is not cleared and must be loaded before it is read.
`default_nettype none
module background_subtraction_motion_mask #(
  parameter int unsigned FRAME_WIDTH  = 480,
  parameter int unsigned FRAME_HEIGHT = 360
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [bsmm_pkg::InDataW-1:0]    s_axis_tdata,  // [7:0] gray
  input  wire logic [bsmm_pkg::InUserW-1:0]    s_axis_tuser,  // [0] cmd, [1] frame_start
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output      logic [bsmm_pkg::OutDataW-1:0]   m_axis_tdata,  // [0] motion, [8:1] background
  input  wire logic                            cfg_we_i,
  input  wire logic [bsmm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bsmm_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import bsmm_pkg::*;

  localparam int unsigned Pixels = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AddrW  = (Pixels > 1) ? $clog2(Pixels) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Pixels - 1);

  typedef logic [AddrW-1:0] addr_t;

  // configuration
  logic [AlphaW-1:0] alpha_q;
  logic [ThrW-1:0]   thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaReset;
      thr_q   <= ThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ALPHA:     alpha_q <= cfg_wdata_i;
        REG_THRESHOLD: thr_q   <= cfg_wdata_i[ThrW-1:0];
        default:       ;
      endcase
    end
  end

  // pipeline control
  logic m_valid_q;
  logic adv;
  logic accept;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // stage 0: address and store read
  addr_t addr_q, addr_d, rd_addr;
  assign rd_addr = s_axis_tuser[1] ? '0 : addr_q;
  assign addr_d  = (rd_addr == LastAddr) ? '0 : rd_addr + addr_t'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (accept) begin
      addr_q <= addr_d;
    end
  end

  logic  s1_valid_q;
  logic  s1_cmd_q;
  pix_t  s1_gray_q;
  addr_t s1_addr_q;

  logic  s2_valid_q;
  logic  s2_cmd_q;
  pix_t  s2_gray_q;
  addr_t s2_addr_q;
  acc_t  s2_nb_q;

  logic  wb_valid_q;
  addr_t wb_addr_q;

  pix_t  m_bg_q;
  logic  m_motion_q;

  logic  wr_en;
  pix_t  s2_result;
  pix_t  rdata_q;
  pix_t  mem [Pixels];

  assign wr_en = adv && s2_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[s2_addr_q] <= s2_result;
    end
    if (accept) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_axis_tvalid;
      s2_valid_q <= s1_valid_q;
      wb_valid_q <= s2_valid_q;
      m_valid_q  <= s2_valid_q;
    end
  end

  // stage 1: forward, then Q16 blend  nb = bg*2^16 + alpha*(gray - bg)
  pix_t                      bg;
  logic [AlphaW-1:0]         alpha_sat;
  logic signed [PixW:0]      diff;
  logic signed [AlphaW+PixW+1:0] prod;
  logic signed [AlphaW+PixW+1:0] nb_full;
  acc_t                      s2_nb_d;

  always_comb begin
    priority if (s2_valid_q && s2_addr_q == s1_addr_q) begin
      bg = s2_result;
    end else if (wb_valid_q && wb_addr_q == s1_addr_q) begin
      bg = m_bg_q;  // written on the same edge this word was read
    end else begin
      bg = rdata_q;
    end
    alpha_sat = alpha_q[AlphaW-1] ? AlphaOne : alpha_q;
    diff      = $signed({1'b0, s1_gray_q}) - $signed({1'b0, bg});
    prod      = $signed({1'b0, alpha_sat}) * diff;
    nb_full   = $signed({{(AlphaW+2-FracW){1'b0}}, bg, {FracW{1'b0}}}) + prod;
    s2_nb_d   = nb_full[AccW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_cmd_q  <= s_axis_tuser[0];
      s1_gray_q <= s_axis_tdata[PixW-1:0];
      s1_addr_q <= rd_addr;
      s2_cmd_q  <= s1_cmd_q;
      s2_gray_q <= s1_gray_q;
      s2_addr_q <= s1_addr_q;
      s2_nb_q   <= s2_nb_d;
    end
  end

  // stage 2: motion test on the unrounded value, round half to even; a load passes gray, no motion
  logic [AccW:0]     lhs, rhs;
  pix_t              whole;
  logic [FracW-1:0]  frac;
  logic              round_up;
  logic [PixW:0]     rounded;
  logic              s2_motion;

  always_comb begin
    lhs      = {1'b0, s2_gray_q, {FracW{1'b0}}};
    rhs      = {1'b0, s2_nb_q} + {1'b0, thr_q, {FracW{1'b0}}};
    whole    = s2_nb_q[AccW-1:FracW];
    frac     = s2_nb_q[FracW-1:0];
    round_up = (frac > FracHalf) || (frac == FracHalf && whole[0]);
    rounded  = {1'b0, whole} + {{PixW{1'b0}}, round_up};
    if (cmd_e'(s2_cmd_q) == CMD_LOAD) begin
      s2_result = s2_gray_q;
      s2_motion = 1'b0;
    end else begin
      s2_result = rounded[PixW] ? '1 : rounded[PixW-1:0];
      s2_motion = lhs > rhs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wb_addr_q  <= s2_addr_q;
      m_bg_q     <= s2_result;
      m_motion_q <= s2_motion;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OutDataW-PixW-1){1'b0}}, m_bg_q, m_motion_q};

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the motion mask block: scoreboard class, stream drivers and checks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsmm_pkg::*;

  localparam int unsigned FRAME_W      = 480;
  localparam int unsigned FRAME_H      = 360;
  localparam int unsigned FRAME_PIXELS = FRAME_W * FRAME_H;
  localparam int unsigned MAX_REPORTS  = 20;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic motion;
    pix_t background;
  } mask_word_t;

  // Running-average background predictor plus the queue of expected mask words.
  class mask_checker;
    pix_t        bg_mem [FRAME_PIXELS];
    int unsigned pix_addr;
    logic [AlphaW-1:0] alpha;
    logic [ThrW-1:0]   thr;
    mask_word_t  expected_masks[$];
    int unsigned errors;
    int unsigned loads;
    int unsigned updates;
    int unsigned motions;

    function new();
      pix_addr = 0;
      alpha    = AlphaReset;
      thr      = ThrReset;
      errors   = 0;
      loads    = 0;
      updates  = 0;
      motions  = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_ALPHA:     alpha = val;
        REG_THRESHOLD: thr = val[ThrW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_masks.size();
    endfunction

    function void note_pixel(cmd_e cmd, pix_t gray, logic fs);
      mask_word_t        w;
      int unsigned       a;
      logic [AlphaW-1:0] k;
      logic [40:0]       blend;
      logic [40:0]       lhs;
      logic [40:0]       rhs;
      logic [24:0]       whole;
      logic [15:0]       frac;
      if (fs) pix_addr = 0;
      if (pix_addr >= FRAME_PIXELS) pix_addr = 0;
      a = pix_addr;
      if (cmd == CMD_LOAD) begin
        w.motion     = 1'b0;
        w.background = gray;
        loads++;
      end else begin
        k     = (alpha > AlphaOne) ? AlphaOne : alpha;
        blend = (41'(AlphaOne) - 41'(k)) * 41'(bg_mem[a]) + 41'(k) * 41'(gray);
        lhs   = 41'(gray) << FracW;
        rhs   = blend + (41'(thr) << FracW);
        w.motion = (lhs > rhs);
        // round half to even on the Q16 blend
        whole = blend[40:16];
        frac  = blend[15:0];
        if (frac > FracHalf || (frac == FracHalf && whole[0])) whole = whole + 1'b1;
        w.background = (whole > 25'd255) ? 8'hFF : whole[7:0];
        updates++;
        if (w.motion) motions++;
      end
      bg_mem[a] = w.background;
      pix_addr  = a + 1;
      if (pix_addr >= FRAME_PIXELS) pix_addr = 0;
      expected_masks = {expected_masks, w};
    endfunction

    function void check_word(logic motion, pix_t bg);
      mask_word_t w;
      if (expected_masks.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, actual motion=%0d bg=%0d",
                   $time, motion, bg);
        return;
      end
      w = expected_masks.pop_front();
      if (w.motion !== motion || w.background !== bg) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch, expected motion=%0d bg=%0d, actual motion=%0d bg=%0d",
                   $time, w.motion, w.background, motion, bg);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // [7:0] gray
  logic [InUserW-1:0]  s_axis_tuser = '0;   // [0] cmd, [1] frame_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // [0] motion, [8:1] background
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  mask_checker sb = new();

  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_req = 1'b0;
  bit          px_loaded [FRAME_PIXELS];
  int unsigned next_addr = 0;
  int unsigned reg_writes = 0;

  background_subtraction_motion_mask #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // A pixel update on a never-loaded address is turned into a load, so the
  // undefined part of the frame store is never read.
  task automatic send_pixel(input cmd_e cmd, input pix_t gray, input logic fs);
    int unsigned gap;
    int unsigned a;
    cmd_e        c;
    c = cmd;
    a = fs ? 0 : next_addr;
    if (a >= FRAME_PIXELS) a = 0;
    if (c == CMD_PROCESS && !px_loaded[a]) c = CMD_LOAD;
    px_loaded[a] = 1'b1;
    next_addr = a + 1;
    gap = tx_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= gray;
    s_axis_tuser  <= {fs, c};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(c, gray, fs);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic setup(input logic [CfgDataW-1:0] alpha, input logic [ThrW-1:0] thr);
    drain();
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_THRESHOLD, CfgDataW'(thr));
  endtask

  // Short frames dominate so that the same address comes back within the
  // pipeline depth and the forwarding paths get exercised.
  task automatic run_frames(input int unsigned n);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    logic        fs;
    cmd_e        c;
    pix_t        g;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      for (k = 0; k < len && sent < n; k++) begin
        fs = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
        c  = ($urandom_range(0, 6) == 0) ? CMD_LOAD : CMD_PROCESS;
        if ($urandom_range(0, 15) == 0) g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else g = pix_t'($urandom_range(0, 255));
        send_pixel(c, g, fs);
        sent++;
      end
    end
  endtask

  // Output side: random stalls per word, one long hold-off on request.
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = rx_gaps ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(m_axis_tdata[0], m_axis_tdata[8:1]);
    end
  end

  initial begin
    logic [CfgDataW-1:0] alpha;
    logic [ThrW-1:0]     thr;
    int unsigned         i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes at reset settings, back-to-back same address
    send_pixel(CMD_LOAD, 8'd0, 1'b1);
    send_pixel(CMD_LOAD, 8'd255, 1'b0);
    send_pixel(CMD_LOAD, 8'd128, 1'b0);
    send_pixel(CMD_PROCESS, 8'd255, 1'b1);
    send_pixel(CMD_PROCESS, 8'd0, 1'b0);
    send_pixel(CMD_PROCESS, 8'd128, 1'b0);
    send_pixel(CMD_PROCESS, 8'd255, 1'b1);
    send_pixel(CMD_PROCESS, 8'd255, 1'b1);
    send_pixel(CMD_PROCESS, 8'd0, 1'b1);
    // half rate: exact ties, both rounding directions
    setup(17'd32768, 8'd0);
    send_pixel(CMD_LOAD, 8'd0, 1'b1);
    send_pixel(CMD_LOAD, 8'd0, 1'b0);
    send_pixel(CMD_LOAD, 8'd1, 1'b0);
    send_pixel(CMD_PROCESS, 8'd1, 1'b1);
    send_pixel(CMD_PROCESS, 8'd3, 1'b0);
    send_pixel(CMD_PROCESS, 8'd2, 1'b0);
    // alpha above one saturates, threshold at max
    setup(17'h1FFFF, 8'd255);
    send_pixel(CMD_PROCESS, 8'd77, 1'b1);
    send_pixel(CMD_PROCESS, 8'd255, 1'b0);
    // frozen background
    setup(17'd0, 8'd0);
    send_pixel(CMD_PROCESS, 8'd255, 1'b1);
    send_pixel(CMD_PROCESS, 8'd0, 1'b0);
    setup(AlphaOne, 8'd254);
    send_pixel(CMD_PROCESS, 8'd255, 1'b1);
    send_pixel(CMD_PROCESS, 8'd0, 1'b0);

    // short burst at full rate on both sides
    setup(AlphaReset, ThrReset);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    for (i = 0; i < 6; i++)
      send_pixel(CMD_PROCESS, pix_t'($urandom_range(0, 255)), 1'b0);

    for (i = 0; i < 8; i++) begin
      case (i)
        0: begin alpha = 17'd0;    thr = 8'd0;   end
        1: begin alpha = AlphaOne; thr = 8'd255; end
        2: begin alpha = 17'h1FFFF; thr = 8'd1;  end
        3: begin alpha = 17'd32768; thr = ThrReset; end
        default: begin
          case ($urandom_range(0, 7))
            0: alpha = 17'd1;
            1: alpha = AlphaReset;
            2: alpha = 17'd32768;
            3: alpha = 17'd65535;
            4: alpha = AlphaOne;
            5: alpha = 17'd65537;
            default: alpha = CfgDataW'($urandom_range(0, 131071));
          endcase
          thr = ($urandom_range(0, 2) == 0) ? ThrReset : pix_t'($urandom_range(0, 255));
        end
      endcase
      setup(alpha, thr);
      tx_gaps = (i % 4 == 0) || (i % 4 == 1);
      rx_gaps = (i % 4 == 0) || (i % 4 == 2);
      // long output hold-off while input keeps coming
      if (i == 0 || i == 5) hold_req = 1'b1;
      run_frames(106);
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d loads and %0d updates (%0d with motion), %0d register writes,",
             sb.loads, sb.updates, sb.motions, reg_writes);
    $display("with rounding ties, saturated alpha, full-rate bursts and two long hold-offs.");
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
